// ===== rtl/pngu_pkg.sv =====
// shared types and constants for the png scanline unfilter
package pngu_pkg;

  localparam int MaxLineBytes  = 16384;
  localparam int MaxPixelBytes = 8;
  localparam int QueueDepth    = 4;

  localparam int LineBytesW  = 15;
  localparam int PixelBytesW = 4;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 15;

  localparam logic [CfgIdxW-1:0] CfgLineBytes  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPixelBytes = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  typedef struct packed {
    logic       bad;
    logic [7:0] data;
    logic       first_row;
    filter_e    filter;
    logic       last;
  } item_ctl_t;

endpackage

// ===== rtl/pngu_front.sv =====
// front end: line tracking, filter byte decode and left slot quotient
module pngu_front import pngu_pkg::*; #(
  parameter int MAX_LINE_BYTES  = MaxLineBytes,
  parameter int MAX_PIXEL_BYTES = MaxPixelBytes,
  localparam int CW = $clog2(MAX_LINE_BYTES + 1),
  localparam int IW = $clog2(MAX_LINE_BYTES),
  localparam int PW = $clog2(MAX_PIXEL_BYTES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    byte_in_i,
  input  logic          pass_start_i,
  input  logic [CW-1:0] len_eff_i,
  input  logic [PW-1:0] p_eff_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output item_ctl_t     q_ctl_o,
  output logic [IW-1:0] q_idx_o,
  output logic [IW-1:0] q_quot_o
);

  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int S  = IW + 3;
  localparam int RW = S + 1;

  logic [CW-1:0] column_q, column_d;
  filter_e       filter_q, filter_d;
  logic          first_row_q, first_row_d;

  logic          in_fire;
  logic          is_filter_byte;
  logic          bad_byte;
  logic [CW-1:0] col_m1, len_m1, idx_full;
  logic          last;
  logic [RW-1:0] recip_tab [MAX_PIXEL_BYTES];
  logic [SW-1:0] p_sel;
  logic [IW+RW-1:0] prod;

  // ceil(2^S / (k+1)) for each pixel size k+1
  for (genvar k = 0; k < MAX_PIXEL_BYTES; k++) begin : g_recip
    localparam longint unsigned Num = (longint'(1) << S) + longint'(k);
    localparam longint unsigned Rec = Num / longint'(k + 1);
    assign recip_tab[k] = RW'(Rec);
  end

  assign in_stall_o     = !q_ready_i;
  assign in_fire        = in_valid_i && q_ready_i;
  assign is_filter_byte = (column_q == '0);
  assign bad_byte       = !(byte_in_i inside {[8'd0:8'd4]});

  assign col_m1   = column_q - CW'(1);
  assign len_m1   = len_eff_i - CW'(1);
  assign idx_full = (col_m1 >= len_eff_i) ? len_m1 : col_m1;
  assign last     = (idx_full == len_m1);

  assign p_sel = SW'(p_eff_i - PW'(1));
  assign prod  = q_idx_o * recip_tab[p_sel];

  assign q_idx_o  = IW'(idx_full);
  assign q_quot_o = prod[S+IW-1:S];
  assign q_push_o = in_fire && (!is_filter_byte || bad_byte);

  always_comb begin
    q_ctl_o.bad       = is_filter_byte;
    q_ctl_o.data      = byte_in_i;
    q_ctl_o.first_row = first_row_q;
    q_ctl_o.filter    = filter_q;
    q_ctl_o.last      = last && !is_filter_byte;
  end

  always_comb begin
    column_d    = column_q;
    filter_d    = filter_q;
    first_row_d = first_row_q;
    if (in_fire) begin
      if (is_filter_byte) begin
        column_d = CW'(1);
        if (pass_start_i) begin
          first_row_d = 1'b1;
        end
        filter_d = bad_byte ? FILT_NONE : filter_e'(byte_in_i[2:0]);
      end else if (last) begin
        column_d    = '0;
        first_row_d = 1'b0;
      end else begin
        column_d = idx_full + CW'(2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      filter_q    <= FILT_NONE;
      first_row_q <= 1'b1;
    end else begin
      column_q    <= column_d;
      filter_q    <= filter_d;
      first_row_q <= first_row_d;
    end
  end

endmodule

// ===== rtl/pngu_fifo.sv =====
// small flop queue between front and back end
module pngu_fifo import pngu_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;

  assign ready_o    = (count_q != NW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + NW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/pngu_back.sv =====
// back end: prior row memory, pixel windows, predictor and output register
module pngu_back import pngu_pkg::*; #(
  parameter int MAX_LINE_BYTES  = MaxLineBytes,
  parameter int MAX_PIXEL_BYTES = MaxPixelBytes,
  localparam int IW = $clog2(MAX_LINE_BYTES),
  localparam int PW = $clog2(MAX_PIXEL_BYTES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [PW-1:0] p_eff_i,
  input  logic          q_valid_i,
  input  item_ctl_t     q_ctl_i,
  input  logic [IW-1:0] q_idx_i,
  input  logic [IW-1:0] q_quot_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    byte_out_o,
  output logic          line_end_o,
  output logic          bad_filter_o
);

  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0]    prior_row_q [MAX_LINE_BYTES];
  logic [7:0]    left_q [MAX_PIXEL_BYTES];
  logic [7:0]    upleft_q [MAX_PIXEL_BYTES];

  logic          c_valid_q;
  item_ctl_t     c_ctl_q;
  logic [IW-1:0] c_idx_q;
  logic [SW-1:0] c_slot_q;
  logic          c_has_left_q;
  logic [7:0]    rd_q;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;

  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_end_q;
  logic          out_bad_q;

  logic          out_free, c_fire, c_we;
  logic [IW-1:0] qp;
  logic [SW-1:0] h_slot;
  logic          h_has_left;
  logic [7:0]    a, b, c, pred, res;
  logic [8:0]    avg_sum;
  logic [9:0]    pa, pb, pc;
  logic signed [9:0] d_bc, d_ac, d_abc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign c_fire   = c_valid_q && out_free;
  assign c_we     = c_fire && !c_ctl_q.bad;
  assign q_pop_o  = q_valid_i && (!c_valid_q || out_free);

  // slot = idx mod pixel size
  assign qp         = IW'(q_quot_i * p_eff_i);
  assign h_slot     = SW'(q_idx_i - qp);
  assign h_has_left = (q_idx_i >= IW'(p_eff_i));

  assign b = c_ctl_q.first_row ? 8'd0 : (fwd_q ? fwd_data_q : rd_q);
  assign a = c_has_left_q ? left_q[c_slot_q] : 8'd0;
  assign c = (c_has_left_q && !c_ctl_q.first_row) ? upleft_q[c_slot_q] : 8'd0;

  assign avg_sum = {1'b0, a} + {1'b0, b};
  assign d_bc    = $signed({2'b00, b}) - $signed({2'b00, c});
  assign d_ac    = $signed({2'b00, a}) - $signed({2'b00, c});
  assign d_abc   = d_bc + d_ac;
  assign pa      = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
  assign pb      = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
  assign pc      = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

  always_comb begin
    case (c_ctl_q.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
  end

  assign res = c_ctl_q.data + pred;

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      prior_row_q[c_idx_q] <= res;
    end
    if (q_pop_o) begin
      rd_q <= prior_row_q[q_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (q_pop_o) begin
        c_valid_q <= 1'b1;
        fwd_q     <= c_we && (c_idx_q == q_idx_i);
      end else if (c_fire) begin
        c_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      c_ctl_q      <= q_ctl_i;
      c_idx_q      <= q_idx_i;
      c_slot_q     <= h_slot;
      c_has_left_q <= h_has_left;
      fwd_data_q   <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else if (c_we) begin
      left_q[c_slot_q]   <= res;
      upleft_q[c_slot_q] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_fire) begin
      out_byte_q <= c_ctl_q.bad ? c_ctl_q.data : res;
      out_end_q  <= c_ctl_q.last;
      out_bad_q  <= c_ctl_q.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_out_o   = out_byte_q;
  assign line_end_o   = out_end_q;
  assign bad_filter_o = out_bad_q;

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// top level of the png scanline unfilter: config registers, front, queue, back
// a data byte is registered in the queue, the back stage and the output register; a valid
// filter byte yields no transaction; one byte per cycle passes unless the output stalls or
// the queue is full, set by one-read one-write prior row memory and one-stage predictor
// reset: line_bytes and pixel_bytes return to 1, the line restarts at a filter byte on the
// first row of a pass, pixel windows clear; prior row contents are undefined until written
module png_scanline_unfilter import pngu_pkg::*; #(
  parameter int MAX_LINE_BYTES  = MaxLineBytes,
  parameter int MAX_PIXEL_BYTES = MaxPixelBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          byte_in_i,
  input  logic                pass_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          byte_out_o,
  output logic                line_end_o,
  output logic                bad_filter_o
);

  localparam int CW = $clog2(MAX_LINE_BYTES + 1);
  localparam int IW = $clog2(MAX_LINE_BYTES);
  localparam int PW = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int LW = ((CW > LineBytesW) ? CW : LineBytesW) + 1;
  localparam int QW = $bits(item_ctl_t) + 2 * IW;

  logic [LineBytesW-1:0]  line_bytes_q;
  logic [PixelBytesW-1:0] pixel_bytes_q;
  logic [LW-1:0]          line_ext;
  logic [PixelBytesW:0]   pix_ext;
  logic [CW-1:0]          len_eff;
  logic [PW-1:0]          p_eff;

  logic          f_push, q_ready, q_valid, q_pop;
  item_ctl_t     f_ctl, b_ctl;
  logic [IW-1:0] f_idx, f_quot, b_idx, b_quot;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q  <= LineBytesW'(1);
      pixel_bytes_q <= PixelBytesW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLineBytes:  line_bytes_q  <= cfg_wdata_i[LineBytesW-1:0];
        CfgPixelBytes: pixel_bytes_q <= cfg_wdata_i[PixelBytesW-1:0];
        default: ;
      endcase
    end
  end

  assign line_ext = LW'(line_bytes_q);
  assign pix_ext  = {1'b0, pixel_bytes_q};

  always_comb begin
    if (line_ext == '0) begin
      len_eff = CW'(1);
    end else if (line_ext > LW'(MAX_LINE_BYTES)) begin
      len_eff = CW'(MAX_LINE_BYTES);
    end else begin
      len_eff = CW'(line_ext);
    end
    if (pix_ext == '0) begin
      p_eff = PW'(1);
    end else if (pix_ext > (PixelBytesW + 1)'(MAX_PIXEL_BYTES)) begin
      p_eff = PW'(MAX_PIXEL_BYTES);
    end else begin
      p_eff = PW'(pix_ext);
    end
  end

  pngu_front #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .pass_start_i (pass_start_i),
    .len_eff_i    (len_eff),
    .p_eff_i      (p_eff),
    .q_ready_i    (q_ready),
    .q_push_o     (f_push),
    .q_ctl_o      (f_ctl),
    .q_idx_o      (f_idx),
    .q_quot_o     (f_quot)
  );

  assign q_wdata = {f_ctl, f_idx, f_quot};

  pngu_fifo #(
    .WIDTH (QW),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_data_i (q_wdata),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  assign {b_ctl, b_idx, b_quot} = q_rdata;

  pngu_back #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .p_eff_i      (p_eff),
    .q_valid_i    (q_valid),
    .q_ctl_i      (b_ctl),
    .q_idx_i      (b_idx),
    .q_quot_i     (b_quot),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_o   (byte_out_o),
    .line_end_o   (line_end_o),
    .bad_filter_o (bad_filter_o)
  );

endmodule
